/* hdl/pcsv_pkg.sv */
`default_nettype none
package pcsv_pkg;

   localparam int CNT_W = 33;

   localparam logic [7:0] PNG_SIG [8] = '{
      8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
   };

   localparam logic [CNT_W-1:0] CNT_SIG_END   = 33'd8;
   localparam logic [CNT_W-1:0] CNT_LEN_END   = 33'd4;
   localparam logic [CNT_W-1:0] CNT_TYPE_END  = 33'd8;
   localparam logic [CNT_W-1:0] CNT_CRC_EXTRA = 33'd12;
   localparam logic [CNT_W-1:0] CNT_TRUNC_MIN = 33'd12;

   localparam logic [31:0] TYPE_IHDR     = 32'h4948_4452;
   localparam logic [31:0] TYPE_IEND     = 32'h4945_4E44;
   localparam logic [7:0]  ANCILLARY_BIT = 8'h20;
   localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
   localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_DATA,
      PH_CRC
   } phase_type;

   typedef enum logic [1:0] {
      VERDICT_OK,
      VERDICT_CORRUPT,
      VERDICT_SUSPECT
   } verdict_type;

   typedef enum logic [2:0] {
      REASON_OK,
      REASON_BAD_SIG,
      REASON_TRUNCATED,
      REASON_CRIT_CRC,
      REASON_ANC_CRC,
      REASON_NO_IHDR,
      REASON_NO_IEND
   } reason_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_END,
      KIND_BYTE_END
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } entry_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

/* hdl/pcsv_front.sv */
`default_nettype none
module pcsv_front
   import pcsv_pkg::*;
(
   input  wire logic      req_tvalid,
   output logic           req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] data_byte
   input  wire logic      req_tuser,    // [0] byte_present
   input  wire logic      req_tlast,    // end_of_file
   input  wire logic      q_full,
   output logic           q_push,
   output entry_type      q_entry
);

   logic useful;

   always_comb begin
      useful          = req_tuser || req_tlast;
      req_tready      = !q_full;
      q_push          = req_tvalid && !q_full && useful;
      q_entry.data    = req_tdata;
      if (req_tuser && req_tlast) begin
         q_entry.kind = KIND_BYTE_END;
      end else if (req_tuser) begin
         q_entry.kind = KIND_BYTE;
      end else begin
         q_entry.kind = KIND_END;
      end
   end

endmodule
`default_nettype wire

/* hdl/pcsv_queue.sv */
`default_nettype none
module pcsv_queue
   import pcsv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   output logic            full,
   output logic            not_empty,
   input  wire logic       pop,
   output entry_type       head
);

   entry_type  slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      full      = (count_ff == 2'd2);
      not_empty = (count_ff != 2'd0);
      head      = slot_ff[rd_ptr_ff];
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("queue count out of range");
`endif

endmodule
`default_nettype wire

/* hdl/pcsv_back.sv */
`default_nettype none
module pcsv_back
   import pcsv_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       q_valid,
   input  wire entry_type  q_head,
   output logic            q_pop,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [39:0]     rsp_tdata    // [1:0] verdict, [4:2] reason, [36:5] chunk_type
);

   phase_type         phase_ff, phase_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [31:0]       chunk_length_ff, chunk_length_in;
   logic [31:0]       type_word_ff, type_word_in;
   logic [31:0]       running_crc_ff, running_crc_in;
   logic [31:0]       stored_crc_ff, stored_crc_in;
   logic              header_seen_ff, header_seen_in;
   logic              first_chunk_ff, first_chunk_in;
   logic              verdict_sent_ff, verdict_sent_in;

   logic              rsp_valid_ff, rsp_valid_in;
   verdict_type       verdict_ff, verdict_in;
   reason_type        reason_ff, reason_in;
   logic [31:0]       chunk_type_ff, chunk_type_in;

   logic              has_byte, has_end;
   logic [CNT_W-1:0]  count_inc, data_end, crc_end;
   logic [31:0]       crc_next;
   logic              emit;
   verdict_type       emit_verdict;
   reason_type        emit_reason;
   logic [31:0]       emit_type;

   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      chunk_length_in = chunk_length_ff;
      type_word_in    = type_word_ff;
      running_crc_in  = running_crc_ff;
      stored_crc_in   = stored_crc_ff;
      header_seen_in  = header_seen_ff;
      first_chunk_in  = first_chunk_ff;
      verdict_sent_in = verdict_sent_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      verdict_in    = verdict_ff;
      reason_in     = reason_ff;
      chunk_type_in = chunk_type_ff;

      emit         = 1'b0;
      emit_verdict = VERDICT_OK;
      emit_reason  = REASON_OK;
      emit_type    = '0;

      has_byte  = (q_head.kind == KIND_BYTE) || (q_head.kind == KIND_BYTE_END);
      has_end   = (q_head.kind == KIND_END) || (q_head.kind == KIND_BYTE_END);
      count_inc = byte_count_ff + 33'd1;
      data_end  = {1'b0, chunk_length_ff} + CNT_TYPE_END;
      crc_end   = {1'b0, chunk_length_ff} + CNT_CRC_EXTRA;
      crc_next  = crc_byte(running_crc_ff, q_head.data);

      q_pop = q_valid && (!rsp_valid_ff || rsp_tready);

      if (q_pop) begin
         if (has_byte && !verdict_sent_ff) begin
            case (phase_ff)
               PH_SIG: begin
                  if (q_head.data != PNG_SIG[byte_count_ff[2:0]]) begin
                     emit         = 1'b1;
                     emit_verdict = VERDICT_CORRUPT;
                     emit_reason  = REASON_BAD_SIG;
                  end else if (count_inc == CNT_SIG_END) begin
                     phase_in        = PH_LEN;
                     byte_count_in   = '0;
                     chunk_length_in = '0;
                     type_word_in    = '0;
                     running_crc_in  = CRC_INIT;
                     stored_crc_in   = '0;
                  end else begin
                     byte_count_in = count_inc;
                  end
               end
               PH_LEN: begin
                  chunk_length_in = {chunk_length_ff[23:0], q_head.data};
                  byte_count_in   = count_inc;
                  if (count_inc == CNT_LEN_END) begin
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE, PH_DATA: begin
                  if (phase_ff == PH_TYPE) begin
                     type_word_in = {type_word_ff[23:0], q_head.data};
                  end
                  running_crc_in = crc_next;
                  byte_count_in  = count_inc;
                  if (count_inc == data_end) begin
                     phase_in = PH_CRC;
                  end else if (phase_ff == PH_TYPE && count_inc == CNT_TYPE_END) begin
                     phase_in = PH_DATA;
                  end
               end
               PH_CRC: begin
                  stored_crc_in = {stored_crc_ff[23:0], q_head.data};
                  byte_count_in = count_inc;
                  if (count_inc >= crc_end) begin
                     if (~running_crc_ff != stored_crc_in) begin
                        emit      = 1'b1;
                        emit_type = type_word_ff;
                        if ((type_word_ff[31:24] & ANCILLARY_BIT) == 8'd0) begin
                           emit_verdict = VERDICT_CORRUPT;
                           emit_reason  = REASON_CRIT_CRC;
                        end else begin
                           emit_verdict = VERDICT_SUSPECT;
                           emit_reason  = REASON_ANC_CRC;
                        end
                     end else begin
                        if (type_word_ff == TYPE_IHDR) begin
                           header_seen_in = first_chunk_ff;
                        end
                        first_chunk_in = 1'b0;
                        if (type_word_ff == TYPE_IEND) begin
                           emit = 1'b1;
                           if (!(type_word_ff == TYPE_IHDR ? first_chunk_ff
                                                           : header_seen_ff)) begin
                              emit_verdict = VERDICT_CORRUPT;
                              emit_reason  = REASON_NO_IHDR;
                           end
                        end else begin
                           phase_in        = PH_LEN;
                           byte_count_in   = '0;
                           chunk_length_in = '0;
                           type_word_in    = '0;
                           running_crc_in  = CRC_INIT;
                           stored_crc_in   = '0;
                        end
                     end
                  end
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
            if (emit) begin
               verdict_sent_in = 1'b1;
            end
         end

         if (has_end) begin
            if (!verdict_sent_in) begin
               emit         = 1'b1;
               emit_verdict = VERDICT_CORRUPT;
               emit_type    = '0;
               if (phase_in == PH_SIG) begin
                  emit_reason = REASON_BAD_SIG;
               end else if (byte_count_in >= CNT_TRUNC_MIN) begin
                  emit_reason = REASON_TRUNCATED;
                  emit_type   = type_word_in;
               end else if (!header_seen_in) begin
                  emit_reason = REASON_NO_IHDR;
               end else begin
                  emit_reason = REASON_NO_IEND;
               end
            end
            phase_in        = PH_SIG;
            byte_count_in   = '0;
            chunk_length_in = '0;
            type_word_in    = '0;
            running_crc_in  = CRC_INIT;
            stored_crc_in   = '0;
            header_seen_in  = 1'b0;
            first_chunk_in  = 1'b1;
            verdict_sent_in = 1'b0;
         end

         if (emit) begin
            rsp_valid_in  = 1'b1;
            verdict_in    = emit_verdict;
            reason_in     = emit_reason;
            chunk_type_in = emit_type;
         end
      end

      rsp_tvalid = rsp_valid_ff;
      rsp_tdata  = {3'd0, chunk_type_ff, reason_ff, verdict_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_SIG;
         byte_count_ff   <= '0;
         chunk_length_ff <= '0;
         type_word_ff    <= '0;
         running_crc_ff  <= CRC_INIT;
         stored_crc_ff   <= '0;
         header_seen_ff  <= 1'b0;
         first_chunk_ff  <= 1'b1;
         verdict_sent_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         chunk_length_ff <= chunk_length_in;
         type_word_ff    <= type_word_in;
         running_crc_ff  <= running_crc_in;
         stored_crc_ff   <= stored_crc_in;
         header_seen_ff  <= header_seen_in;
         first_chunk_ff  <= first_chunk_in;
         verdict_sent_ff <= verdict_sent_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      verdict_ff    <= verdict_in;
      reason_ff     <= reason_in;
      chunk_type_ff <= chunk_type_in;
   end

`ifndef SYNTHESIS
   a_sig_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SIG |-> byte_count_ff < CNT_SIG_END)
      else $error("signature count past end");
   a_len_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_LEN |-> byte_count_ff < CNT_LEN_END)
      else $error("length count past end");
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> byte_count_ff >= CNT_TYPE_END)
      else $error("data phase before type complete");
   a_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && verdict_ff == VERDICT_OK |->
         reason_ff == REASON_OK && chunk_type_ff == 32'd0)
      else $error("ok verdict with reason or type");
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |-> !q_pop)
      else $error("request taken while result stalled");
`endif

endmodule
`default_nettype wire

/* hdl/png_chunk_stream_validator.sv */
`default_nettype none
// PNG chunk stream validator. Takes one file byte per request (req_tuser set) with req_tlast
// on the final request of each file; a request with req_tuser clear carries no byte and
// only matters with req_tlast, e.g. for an empty file. Requests pass a classifier into a
// two-entry queue; the checker behind it retires one request per cycle, byte-wise CRC-32
// update and framing counters included, so the block sustains one byte per clock while
// rsp is not stalled. Exactly one verdict per file leaves on rsp after its deciding request
// (IEND, first error or end of file); bytes after a verdict are dropped up to end of file.
module png_chunk_stream_validator
   import pcsv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] byte_present
   input  wire logic        req_tlast,   // end_of_file
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // [1:0] verdict, [4:2] reason, [36:5] chunk_type
);

   logic      q_full, q_push, q_valid, q_pop;
   entry_type q_entry, q_head;

   pcsv_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_entry    (q_entry)
   );

   pcsv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .full       (q_full),
      .not_empty  (q_valid),
      .pop        (q_pop),
      .head       (q_head)
   );

   pcsv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
   import pcsv_pkg::*;

   localparam int CYCLE_LIMIT = 200_000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      verdict_type verdict;
      reason_type  reason;
      logic [31:0] ctype;
   } verdict_rec;

   typedef enum int {
      FILE_VALID,
      FILE_NO_IHDR,
      FILE_LATE_IHDR,
      FILE_BAD_CRC,
      FILE_CUT_CHUNK,
      FILE_REPEAT_IHDR,
      FILE_SIG_NOISE,
      FILE_GARBAGE_CHUNKS
   } file_kind_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] data_byte
   logic        req_tuser = 1'b0;    // [0] byte_present
   logic        req_tlast = 1'b0;    // end_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [1:0] verdict, [4:2] reason, [36:5] chunk_type

   png_chunk_stream_validator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   verdict_rec  expected_verdicts[$];
   logic [7:0]  png_bytes[$];
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   int          hold_left = 0;
   int          file_serial = 0;

   // parser state mirror
   phase_type        parse_phase;
   logic [CNT_W-1:0] byte_index;
   logic [31:0]      length_acc;
   logic [31:0]      type_acc;
   logic [31:0]      crc_acc;
   logic [31:0]      stored_crc_acc;
   bit               ihdr_ok;
   bit               at_first_chunk;
   bit               verdict_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic flag_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("ERROR @%0d: %s", cycle_count, what);
   endtask

   always @(posedge clock) begin : check_verdicts
      verdict_rec want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_verdicts.size() == 0) begin
            flag_mismatch($sformatf("verdict with none pending, tdata %h", rsp_tdata));
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_tdata[1:0] !== want.verdict)
               flag_mismatch($sformatf("verdict %0d, want %0d", rsp_tdata[1:0], want.verdict));
            if (rsp_tdata[4:2] !== want.reason)
               flag_mismatch($sformatf("reason %0d, want %0d", rsp_tdata[4:2], want.reason));
            if (rsp_tdata[36:5] !== want.ctype)
               flag_mismatch($sformatf("chunk_type %h, want %h", rsp_tdata[36:5], want.ctype));
         end
      end
   end

   function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = c[0] ^ d[i];
         c = {1'b0, c[31:1]};
         if (fb)
            c = c ^ 32'hEDB8_8320;
      end
      return c;
   endfunction

   function automatic void post_verdict(input verdict_type v, input reason_type r,
                                        input logic [31:0] t);
      verdict_rec rec;
      rec.verdict = v;
      rec.reason = r;
      rec.ctype = t;
      expected_verdicts.push_back(rec);
      verdict_done = 1'b1;
   endfunction

   function automatic void begin_chunk();
      parse_phase = PH_LEN;
      byte_index = '0;
      length_acc = '0;
      type_acc = '0;
      crc_acc = '1;
      stored_crc_acc = '0;
   endfunction

   function automatic void clear_parser();
      begin_chunk();
      parse_phase = PH_SIG;
      ihdr_ok = 1'b0;
      at_first_chunk = 1'b1;
      verdict_done = 1'b0;
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      case (parse_phase)
         PH_SIG: begin
            if (b != PNG_SIG[byte_index[2:0]]) begin
               post_verdict(VERDICT_CORRUPT, REASON_BAD_SIG, '0);
            end else begin
               byte_index++;
               if (byte_index >= CNT_SIG_END)
                  begin_chunk();
            end
         end
         PH_LEN: begin
            length_acc = {length_acc[23:0], b};
            byte_index++;
            if (byte_index == CNT_LEN_END)
               parse_phase = PH_TYPE;
         end
         PH_TYPE, PH_DATA: begin
            if (parse_phase == PH_TYPE)
               type_acc = {type_acc[23:0], b};
            crc_acc = crc32_step(crc_acc, b);
            byte_index++;
            if (byte_index == {1'b0, length_acc} + CNT_TYPE_END)
               parse_phase = PH_CRC;
            else if (parse_phase == PH_TYPE && byte_index == CNT_TYPE_END)
               parse_phase = PH_DATA;
         end
         default: begin
            stored_crc_acc = {stored_crc_acc[23:0], b};
            byte_index++;
            if (byte_index >= {1'b0, length_acc} + CNT_CRC_EXTRA) begin
               if (~crc_acc != stored_crc_acc) begin
                  if (type_acc[29] == 1'b0)
                     post_verdict(VERDICT_CORRUPT, REASON_CRIT_CRC, type_acc);
                  else
                     post_verdict(VERDICT_SUSPECT, REASON_ANC_CRC, type_acc);
               end else begin
                  if (type_acc == TYPE_IHDR)
                     ihdr_ok = at_first_chunk;
                  at_first_chunk = 1'b0;
                  if (type_acc == TYPE_IEND) begin
                     if (ihdr_ok)
                        post_verdict(VERDICT_OK, REASON_OK, '0);
                     else
                        post_verdict(VERDICT_CORRUPT, REASON_NO_IHDR, '0);
                  end else begin
                     begin_chunk();
                  end
               end
            end
         end
      endcase
   endfunction

   function automatic void predict_request(input logic [7:0] b, input bit present,
                                           input bit last);
      if (!verdict_done && present)
         parse_byte(b);
      if (last) begin
         if (!verdict_done) begin
            if (parse_phase == PH_SIG)
               post_verdict(VERDICT_CORRUPT, REASON_BAD_SIG, '0);
            else if (byte_index >= CNT_TRUNC_MIN)
               post_verdict(VERDICT_CORRUPT, REASON_TRUNCATED, type_acc);
            else if (!ihdr_ok)
               post_verdict(VERDICT_CORRUPT, REASON_NO_IHDR, '0);
            else
               post_verdict(VERDICT_CORRUPT, REASON_NO_IEND, '0);
         end
         clear_parser();
      end
   endfunction

   task automatic put_request(input logic [7:0] d, input bit present, input bit last);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct)
         gap = $urandom_range(4, 1);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= d;
      req_tuser <= present;
      req_tlast <= last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      predict_request(d, present, last);
   endtask

   task automatic send_file();
      bit tail_end;
      tail_end = 1'($urandom_range(1));
      if (png_bytes.size() == 0)
         tail_end = 1'b1;
      foreach (png_bytes[i]) begin
         if ($urandom_range(19) == 0)
            put_request(8'($urandom), 1'b0, 1'b0);
         put_request(png_bytes[i], 1'b1, !tail_end && i == png_bytes.size() - 1);
      end
      if (tail_end)
         put_request(8'($urandom), 1'b0, 1'b1);
   endtask

   task automatic add_word(input logic [31:0] w);
      for (int i = 3; i >= 0; i--)
         png_bytes.push_back(w[i*8 +: 8]);
   endtask

   task automatic add_signature();
      foreach (PNG_SIG[i])
         png_bytes.push_back(PNG_SIG[i]);
   endtask

   task automatic add_chunk(input logic [31:0] ctype, input int unsigned len, input bit bad_crc);
      logic [31:0] crc;
      logic [7:0]  d;
      add_word(len);
      add_word(ctype);
      crc = '1;
      for (int i = 3; i >= 0; i--)
         crc = crc32_step(crc, ctype[i*8 +: 8]);
      for (int unsigned i = 0; i < len; i++) begin
         d = 8'($urandom);
         crc = crc32_step(crc, d);
         png_bytes.push_back(d);
      end
      crc = ~crc;
      if (bad_crc)
         crc = crc ^ (32'd1 << $urandom_range(31));
      add_word(crc);
   endtask

   function automatic logic [31:0] random_type();
      logic [31:0] t;
      for (int i = 0; i < 4; i++)
         t[i*8 +: 8] = (8'h41 + 8'($urandom_range(25))) | ($urandom_range(1) ? 8'h20 : 8'h00);
      return t;
   endfunction

   function automatic int unsigned short_len();
      return ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(4);
   endfunction

   task automatic test_signature_edges();
      put_request(8'h00, 1'b0, 1'b1);
      put_request(8'h00, 1'b1, 1'b1);
      put_request(8'h89, 1'b1, 1'b0);
      put_request(8'hFF, 1'b0, 1'b0);
      put_request(8'h50, 1'b1, 1'b1);
      for (int i = 0; i < 7; i++)
         put_request(PNG_SIG[i], 1'b1, 1'b0);
      put_request(8'hFF, 1'b1, 1'b0);
      put_request(8'h0A, 1'b1, 1'b0);
      put_request(8'h00, 1'b1, 1'b0);
      put_request(8'h00, 1'b0, 1'b1);
      foreach (PNG_SIG[i])
         put_request(PNG_SIG[i], 1'b1, 1'b0);
      put_request(8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_random_files(input int n);
      file_kind_type kind;
      int unsigned   len;
      int            mark;
      int            keep;
      for (int f = 0; f < n; f++) begin
         png_bytes.delete();
         kind = file_kind_type'(file_serial % 8);
         file_serial++;
         case (kind)
            FILE_VALID: begin
               add_signature();
               add_chunk(TYPE_IHDR, $urandom_range(1) ? 13 : short_len(), 1'b0);
               repeat ($urandom_range(2)) add_chunk(random_type(), short_len(), 1'b0);
               add_chunk(TYPE_IEND, 0, 1'b0);
            end
            FILE_NO_IHDR: begin
               add_signature();
               repeat ($urandom_range(2)) add_chunk(random_type(), short_len(), 1'b0);
               add_chunk(TYPE_IEND, 0, 1'b0);
            end
            FILE_LATE_IHDR: begin
               add_signature();
               add_chunk(random_type(), short_len(), 1'b0);
               add_chunk(TYPE_IHDR, short_len(), 1'b0);
               add_chunk(TYPE_IEND, 0, 1'b0);
            end
            FILE_BAD_CRC: begin
               add_signature();
               add_chunk(TYPE_IHDR, short_len(), 1'b0);
               add_chunk(random_type(), short_len(), 1'b1);
               if ($urandom_range(1))
                  add_chunk(TYPE_IEND, 0, 1'b0);
            end
            FILE_CUT_CHUNK: begin
               add_signature();
               add_chunk(TYPE_IHDR, short_len(), 1'b0);
               if ($urandom_range(3) == 0) begin
                  add_word({24'hFF_FFFF, 8'($urandom)});
                  add_word(random_type());
                  repeat ($urandom_range(12, 4)) png_bytes.push_back(8'($urandom));
               end else begin
                  len = $urandom_range(8, 1);
                  mark = png_bytes.size();
                  add_chunk(random_type(), len, 1'b0);
                  keep = $urandom_range(11 + len, 1);
                  while (png_bytes.size() > mark + keep)
                     void'(png_bytes.pop_back());
               end
            end
            FILE_REPEAT_IHDR: begin
               add_signature();
               add_chunk(TYPE_IHDR, short_len(), 1'b0);
               add_chunk(TYPE_IHDR, short_len(), 1'b0);
               add_chunk(TYPE_IEND, 0, 1'b0);
            end
            FILE_SIG_NOISE: begin
               for (int i = 0; i < $urandom_range(7); i++)
                  png_bytes.push_back(PNG_SIG[i]);
               repeat ($urandom_range(4, 1)) png_bytes.push_back(8'($urandom));
            end
            default: begin
               add_signature();
               repeat ($urandom_range(24, 4)) png_bytes.push_back(8'($urandom));
            end
         endcase
         if (kind != FILE_CUT_CHUNK && $urandom_range(3) == 0)
            repeat ($urandom_range(3, 1)) png_bytes.push_back(8'($urandom));
         send_file();
      end
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_left = 300;
      repeat (30) put_request(8'($urandom_range(8'h88)), 1'b1, 1'b1);
   endtask

   initial begin
      clear_parser();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_signature_edges();

      send_idle_pct = 0;
      stall_pct = 0;
      test_random_files(2);
      send_idle_pct = 47;
      stall_pct = 0;
      test_random_files(2);
      send_idle_pct = 0;
      stall_pct = 47;
      test_random_files(2);
      send_idle_pct = 14;
      stall_pct = 14;
      test_random_files(2);

      test_backpressure();
      req_tvalid <= 1'b0;

      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* filelist.f */
hdl/pcsv_pkg.sv
hdl/pcsv_front.sv
hdl/pcsv_queue.sv
hdl/pcsv_back.sv
hdl/png_chunk_stream_validator.sv
tb/sv/tb_top.sv
